// ===== rtl/ppmer_pkg.sv =====
// Shared constants and the sequencer state type for the parabolic edge reconstruction block.
`timescale 1ns / 1ps

package ppmer_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LIMITER_ENABLE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOURTH_ORDER   = 1'b1;

	// Guard bits above the sample width for all internal sums
	localparam int EXT_BITS = 8;

	// Divide-by-twelve unit: quotient bits retired per cycle, remainder width
	localparam int DIGIT_BITS = 8;
	localparam int REM_BITS   = 4;
	localparam logic [REM_BITS:0] DIV_TWELVE = 5'd12;

	// Column fill count marks
	localparam logic [2:0] CNT_FIRST_IFACE = 3'd3;
	localparam logic [2:0] CNT_FULL        = 3'd4;

	localparam int NUM_STATES = 44;

	typedef enum logic [NUM_STATES-1:0] {
		ST_IDLE    = NUM_STATES'(1) << 0,
		ST_F_SUM   = NUM_STATES'(1) << 1,
		ST_F_OUT   = NUM_STATES'(1) << 2,
		ST_F_MUL7  = NUM_STATES'(1) << 3,
		ST_F_NUM   = NUM_STATES'(1) << 4,
		ST_S_D0    = NUM_STATES'(1) << 5,
		ST_S_D1    = NUM_STATES'(1) << 6,
		ST_S_D2    = NUM_STATES'(1) << 7,
		ST_S_C2    = NUM_STATES'(1) << 8,
		ST_S_S2    = NUM_STATES'(1) << 9,
		ST_S_L2    = NUM_STATES'(1) << 10,
		ST_S_C1    = NUM_STATES'(1) << 11,
		ST_S_S1    = NUM_STATES'(1) << 12,
		ST_S_L1    = NUM_STATES'(1) << 13,
		ST_S_U     = NUM_STATES'(1) << 14,
		ST_S_U6    = NUM_STATES'(1) << 15,
		ST_S_SUB   = NUM_STATES'(1) << 16,
		ST_S_NUM   = NUM_STATES'(1) << 17,
		ST_D_BIAS  = NUM_STATES'(1) << 18,
		ST_D_DIV   = NUM_STATES'(1) << 19,
		ST_D_UNB   = NUM_STATES'(1) << 20,
		ST_M_RA    = NUM_STATES'(1) << 21,
		ST_M_AL    = NUM_STATES'(1) << 22,
		ST_M_D     = NUM_STATES'(1) << 23,
		ST_M_LR    = NUM_STATES'(1) << 24,
		ST_M_6A    = NUM_STATES'(1) << 25,
		ST_M_3LR   = NUM_STATES'(1) << 26,
		ST_M_SM    = NUM_STATES'(1) << 27,
		ST_M_T1    = NUM_STATES'(1) << 28,
		ST_M_3A    = NUM_STATES'(1) << 29,
		ST_M_NL    = NUM_STATES'(1) << 30,
		ST_M_D2    = NUM_STATES'(1) << 31,
		ST_M_LR2   = NUM_STATES'(1) << 32,
		ST_M_3LR2  = NUM_STATES'(1) << 33,
		ST_M_SM2   = NUM_STATES'(1) << 34,
		ST_M_T2    = NUM_STATES'(1) << 35,
		ST_M_NR    = NUM_STATES'(1) << 36,
		ST_M_CA    = NUM_STATES'(1) << 37,
		ST_M_RLO   = NUM_STATES'(1) << 38,
		ST_M_RHI   = NUM_STATES'(1) << 39,
		ST_M_CB    = NUM_STATES'(1) << 40,
		ST_M_LLO   = NUM_STATES'(1) << 41,
		ST_M_LHI   = NUM_STATES'(1) << 42,
		ST_FIN     = NUM_STATES'(1) << 43
	} state_t;

endpackage

// ===== rtl/ppm_edge_reconstruction.sv =====
// Top level: streaming parabolic edge reconstruction with optional extremum limiter.
`timescale 1ns / 1ps

// Samples of one grid column enter one per request in signed fixed point (SAMPLE_BITS wide);
// column_start marks the first sample of a column. From the fifth sample of a column on, each
// request returns the left and right edge values of the cell two samples back, saturated to
// the sample range. Interface values come from the fourth-order formula or from monotonized
// van Leer slopes (REG_FOURTH_ORDER), and the limiter (REG_LIMITER_ENABLE) flattens extrema,
// stops parabola overshoot and clamps each edge between the cell and its neighbour. Work is
// done by one shared adder/comparator that performs one add, subtract or compare per cycle
// under a sequencer, plus a divide-by-twelve unit that retires eight quotient bits per cycle.
// A request with fewer than three samples of the column before it only fills the window; any
// other request runs the fourth-order formula or the limited slopes and the divider, then the
// limiter steps when a result is produced with the limiter on. in_ready is high only between
// requests; a finished result also waits for its output slot to free up.
module ppm_edge_reconstruction
	import ppmer_pkg::*;
#(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          column_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_edge,
	output logic signed [SAMPLE_BITS-1:0] right_edge,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic                          cfg_data
);

	localparam int AW     = SAMPLE_BITS + EXT_BITS;
	localparam int DIGITS = (AW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIVW   = DIGITS * DIGIT_BITS;
	localparam int DCW    = $clog2(DIGITS);
	// Offset keeps the dividend positive: floor((n+6)/12) + 2^(SAMPLE_BITS+3)
	localparam logic [AW-1:0] DIV_BIAS   = (AW'(3) << (SAMPLE_BITS + 5)) + AW'(6);
	localparam logic [AW-1:0] DIV_OFFSET = AW'(1) << (SAMPLE_BITS + 3);

	function automatic logic [AW-1:0] ext(input logic [SAMPLE_BITS-1:0] v);
		return {{EXT_BITS{v[SAMPLE_BITS-1]}}, v};
	endfunction

	function automatic logic is_neg(input logic [AW-1:0] v);
		return v[AW-1];
	endfunction

	function automatic logic is_pos(input logic [AW-1:0] v);
		return !v[AW-1] && (|v);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] sat(input logic [AW-1:0] v);
		logic [SAMPLE_BITS-1:0] r;
		if ((&v[AW-1:SAMPLE_BITS-1]) || !(|v[AW-1:SAMPLE_BITS-1]))
			r = v[SAMPLE_BITS-1:0];
		else if (v[AW-1])
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		return r;
	endfunction

	state_t state_q, state_d;

	logic [2:0]             cnt_q;
	logic [SAMPLE_BITS-1:0] win0_q, win1_q, win2_q, prev_q;
	logic                   limiter_q, fourth_q;
	logic                   out_valid_q;
	logic [DCW-1:0]         dcnt_q;

	logic [SAMPLE_BITS-1:0] x_q, iface_q, left_q, right_q;
	logic [AW-1:0]          t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, l_q, r_q;
	logic [DIVW-1:0]        div_q;
	logic [REM_BITS-1:0]    rem_q;
	logic                   flag_q;

	logic [AW-1:0] a_x, am_x, ap_x, x_x;
	logic [AW-1:0] opa, opb, alu_res;
	logic          sub;
	logic          res_neg, res_pos;

	logic [2:0]            cnt_eff;
	logic                  accept, emit, fin_go, fin_load;
	logic                  same2, same1, flat, tip;

	logic [REM_BITS-1:0]   rem_v;
	logic [REM_BITS:0]     part_v;
	logic [DIGIT_BITS-1:0] qdig;
	logic [DIVW-1:0]       div_next;

	assign a_x  = ext(win1_q);
	assign am_x = ext(win0_q);
	assign ap_x = ext(win2_q);
	assign x_x  = ext(x_q);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cnt_eff    = column_start ? 3'd0 : cnt_q;
	assign emit       = (cnt_q == CNT_FULL);
	assign fin_go     = !emit || !out_valid_q || out_ready;
	assign fin_load   = (state_q == ST_FIN) && emit && fin_go;
	assign out_valid  = out_valid_q;
	assign left_edge  = left_q;
	assign right_edge = right_q;

	// Shared adder/comparator: one operation per sequencer step
	always_comb begin
		opa = '0;
		opb = '0;
		sub = 1'b0;
		unique case (state_q)
			ST_F_SUM:  begin opa = a_x;          opb = ap_x;                     end
			ST_F_OUT:  begin opa = am_x;         opb = x_x;                      end
			ST_F_MUL7: begin opa = t0_q << 3;    opb = t0_q;        sub = 1'b1;  end
			ST_F_NUM:  begin opa = t0_q;         opb = t1_q;        sub = 1'b1;  end
			ST_S_D0:   begin opa = a_x;          opb = am_x;        sub = 1'b1;  end
			ST_S_D1:   begin opa = ap_x;         opb = a_x;         sub = 1'b1;  end
			ST_S_D2:   begin opa = x_x;          opb = ap_x;        sub = 1'b1;  end
			ST_S_C2:   begin opa = t0_q;         opb = t1_q;        sub = 1'b1;  end
			ST_S_S2:   begin opa = t0_q;         opb = t1_q;                     end
			ST_S_L2:   begin opa = t4_q;         opb = t3_q << 2;   sub = 1'b1;  end
			ST_S_C1:   begin opa = t1_q;         opb = t2_q;        sub = 1'b1;  end
			ST_S_S1:   begin opa = t1_q;         opb = t2_q;                     end
			ST_S_L1:   begin opa = t4_q;         opb = t3_q << 2;   sub = 1'b1;  end
			ST_S_U:    begin opa = a_x;          opb = ap_x;                     end
			ST_S_U6:   begin opa = t1_q << 2;    opb = t1_q << 1;                end
			ST_S_SUB:  begin opa = t1_q;         opb = t0_q;        sub = 1'b1;  end
			ST_S_NUM:  begin opa = t1_q;         opb = t5_q;                     end
			ST_D_BIAS: begin opa = t0_q;         opb = DIV_BIAS;                 end
			ST_D_UNB:  begin opa = AW'(div_q);   opb = DIV_OFFSET;  sub = 1'b1;  end
			ST_M_RA:   begin opa = r_q;          opb = a_x;         sub = 1'b1;  end
			ST_M_AL:   begin opa = a_x;          opb = l_q;         sub = 1'b1;  end
			ST_M_D:    begin opa = r_q;          opb = l_q;         sub = 1'b1;  end
			ST_M_LR:   begin opa = l_q;          opb = r_q;                      end
			ST_M_6A:   begin opa = a_x << 2;     opb = a_x << 1;                 end
			ST_M_3LR:  begin opa = t1_q << 1;    opb = t1_q;                     end
			ST_M_SM:   begin opa = t4_q;         opb = t3_q;        sub = 1'b1;  end
			ST_M_T1:   begin opa = t0_q;         opb = t2_q;        sub = 1'b1;  end
			ST_M_3A:   begin opa = a_x << 1;     opb = a_x;                      end
			ST_M_NL:   begin opa = t5_q;         opb = r_q << 1;    sub = 1'b1;  end
			ST_M_D2:   begin opa = r_q;          opb = l_q;         sub = 1'b1;  end
			ST_M_LR2:  begin opa = l_q;          opb = r_q;                      end
			ST_M_3LR2: begin opa = t1_q << 1;    opb = t1_q;                     end
			ST_M_SM2:  begin opa = t3_q;         opb = t4_q;        sub = 1'b1;  end
			ST_M_T2:   begin opa = t0_q;         opb = t2_q;        sub = 1'b1;  end
			ST_M_NR:   begin opa = t5_q;         opb = l_q << 1;    sub = 1'b1;  end
			ST_M_CA:   begin opa = a_x;          opb = ap_x;        sub = 1'b1;  end
			ST_M_RLO:  begin opa = r_q;          opb = t0_q;        sub = 1'b1;  end
			ST_M_RHI:  begin opa = r_q;          opb = t1_q;        sub = 1'b1;  end
			ST_M_CB:   begin opa = am_x;         opb = a_x;         sub = 1'b1;  end
			ST_M_LLO:  begin opa = l_q;          opb = t0_q;        sub = 1'b1;  end
			ST_M_LHI:  begin opa = l_q;          opb = t1_q;        sub = 1'b1;  end
			default:   begin opa = '0;           opb = '0;                       end
		endcase
	end

	assign alu_res = opa + (sub ? ~opb : opb) + AW'(sub);
	assign res_neg = is_neg(alu_res);
	assign res_pos = is_pos(alu_res);

	// Slopes count only when both one-sided differences share a strict sign
	assign same2 = (is_pos(t0_q) && is_pos(t1_q)) || (is_neg(t0_q) && is_neg(t1_q));
	assign same1 = (is_pos(t1_q) && is_pos(t2_q)) || (is_neg(t1_q) && is_neg(t2_q));
	// Flatten when the cell is a local extremum
	assign flat  = !((is_pos(t0_q) && res_pos) || (is_neg(t0_q) && res_neg));
	// Overshoot test: d and (d - 6m) of opposite strict sign
	assign tip   = (is_pos(t0_q) && res_neg) || (is_neg(t0_q) && res_pos);

	// Restoring divide by twelve, several quotient bits per cycle
	always_comb begin
		rem_v  = rem_q;
		part_v = '0;
		qdig   = '0;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			part_v = {rem_v, div_q[DIVW-1-i]};
			if (part_v >= DIV_TWELVE) begin
				qdig[DIGIT_BITS-1-i] = 1'b1;
				part_v = part_v - DIV_TWELVE;
			end
			rem_v = part_v[REM_BITS-1:0];
		end
		div_next = {div_q[DIVW-DIGIT_BITS-1:0], qdig};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cnt_eff >= CNT_FIRST_IFACE))
					state_d = fourth_q ? ST_F_SUM : ST_S_D0;
			end
			ST_F_SUM:  state_d = ST_F_OUT;
			ST_F_OUT:  state_d = ST_F_MUL7;
			ST_F_MUL7: state_d = ST_F_NUM;
			ST_F_NUM:  state_d = ST_D_BIAS;
			ST_S_D0:   state_d = ST_S_D1;
			ST_S_D1:   state_d = ST_S_D2;
			ST_S_D2:   state_d = ST_S_C2;
			ST_S_C2:   state_d = ST_S_S2;
			ST_S_S2:   state_d = ST_S_L2;
			ST_S_L2:   state_d = ST_S_C1;
			ST_S_C1:   state_d = ST_S_S1;
			ST_S_S1:   state_d = ST_S_L1;
			ST_S_L1:   state_d = ST_S_U;
			ST_S_U:    state_d = ST_S_U6;
			ST_S_U6:   state_d = ST_S_SUB;
			ST_S_SUB:  state_d = ST_S_NUM;
			ST_S_NUM:  state_d = ST_D_BIAS;
			ST_D_BIAS: state_d = ST_D_DIV;
			ST_D_DIV: begin
				if (dcnt_q == '0)
					state_d = ST_D_UNB;
			end
			ST_D_UNB:  state_d = (emit && limiter_q) ? ST_M_RA : ST_FIN;
			ST_M_RA:   state_d = ST_M_AL;
			ST_M_AL:   state_d = ST_M_D;
			ST_M_D:    state_d = ST_M_LR;
			ST_M_LR:   state_d = ST_M_6A;
			ST_M_6A:   state_d = ST_M_3LR;
			ST_M_3LR:  state_d = ST_M_SM;
			ST_M_SM:   state_d = ST_M_T1;
			ST_M_T1:   state_d = ST_M_3A;
			ST_M_3A:   state_d = ST_M_NL;
			ST_M_NL:   state_d = ST_M_D2;
			ST_M_D2:   state_d = ST_M_LR2;
			ST_M_LR2:  state_d = ST_M_3LR2;
			ST_M_3LR2: state_d = ST_M_SM2;
			ST_M_SM2:  state_d = ST_M_T2;
			ST_M_T2:   state_d = ST_M_NR;
			ST_M_NR:   state_d = ST_M_CA;
			ST_M_CA:   state_d = ST_M_RLO;
			ST_M_RLO:  state_d = ST_M_RHI;
			ST_M_RHI:  state_d = ST_M_CB;
			ST_M_CB:   state_d = ST_M_LLO;
			ST_M_LLO:  state_d = ST_M_LHI;
			ST_M_LHI:  state_d = ST_FIN;
			ST_FIN: begin
				if (fin_go)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			win0_q      <= '0;
			win1_q      <= '0;
			win2_q      <= '0;
			prev_q      <= '0;
			limiter_q   <= 1'b1;
			fourth_q    <= 1'b0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				if (cfg_index == REG_LIMITER_ENABLE)
					limiter_q <= cfg_data;
				if (cfg_index == REG_FOURTH_ORDER)
					fourth_q <= cfg_data;
			end

			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (accept) begin
				if (cnt_eff < CNT_FIRST_IFACE) begin
					// no interface yet: shift the window and count
					win0_q <= win1_q;
					win1_q <= win2_q;
					win2_q <= sample;
					cnt_q  <= cnt_eff + 3'd1;
				end else begin
					cnt_q <= cnt_eff;
				end
			end

			if (state_q == ST_D_BIAS)
				dcnt_q <= DCW'(DIGITS - 1);
			else if (state_q == ST_D_DIV)
				dcnt_q <= dcnt_q - DCW'(1);

			if ((state_q == ST_FIN) && fin_go) begin
				win0_q <= win1_q;
				win1_q <= win2_q;
				win2_q <= x_q;
				prev_q <= iface_q;
				cnt_q  <= CNT_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			x_q <= sample;

		if (fin_load) begin
			left_q  <= l_q[SAMPLE_BITS-1:0];
			right_q <= r_q[SAMPLE_BITS-1:0];
		end

		unique case (state_q)
			ST_F_SUM:  t0_q <= alu_res;
			ST_F_OUT:  t1_q <= alu_res;
			ST_F_MUL7: t0_q <= alu_res;
			ST_F_NUM:  t0_q <= alu_res;
			ST_S_D0:   t0_q <= alu_res;
			ST_S_D1:   t1_q <= alu_res;
			ST_S_D2:   t2_q <= alu_res;
			// min of the differences when rising, max when falling
			ST_S_C2:   t3_q <= is_pos(t0_q) ? (res_neg ? t0_q : t1_q) : (res_neg ? t1_q : t0_q);
			ST_S_S2:   t4_q <= alu_res;
			ST_S_L2: begin
				if (!same2)
					t5_q <= '0;
				else if (is_pos(t0_q))
					t5_q <= res_neg ? t4_q : (t3_q << 2);
				else
					t5_q <= res_neg ? (t3_q << 2) : t4_q;
			end
			ST_S_C1:   t3_q <= is_pos(t1_q) ? (res_neg ? t1_q : t2_q) : (res_neg ? t2_q : t1_q);
			ST_S_S1:   t4_q <= alu_res;
			ST_S_L1: begin
				if (!same1)
					t0_q <= '0;
				else if (is_pos(t1_q))
					t0_q <= res_neg ? t4_q : (t3_q << 2);
				else
					t0_q <= res_neg ? (t3_q << 2) : t4_q;
			end
			ST_S_U:    t1_q <= alu_res;
			ST_S_U6:   t1_q <= alu_res;
			ST_S_SUB:  t1_q <= alu_res;
			ST_S_NUM:  t0_q <= alu_res;
			ST_D_BIAS: begin
				div_q <= DIVW'(alu_res);
				rem_q <= '0;
			end
			ST_D_DIV: begin
				div_q <= div_next;
				rem_q <= rem_v;
			end
			ST_D_UNB: begin
				iface_q <= sat(alu_res);
				l_q     <= ext(prev_q);
				r_q     <= ext(sat(alu_res));
			end
			ST_M_RA:   t0_q <= alu_res;
			ST_M_AL: begin
				if (flat) begin
					l_q <= a_x;
					r_q <= a_x;
				end
			end
			ST_M_D:    t0_q <= alu_res;
			ST_M_LR:   t1_q <= alu_res;
			ST_M_6A:   t4_q <= alu_res;
			ST_M_3LR:  t3_q <= alu_res;
			ST_M_SM:   t2_q <= alu_res;
			ST_M_T1:   flag_q <= tip;
			ST_M_3A:   t5_q <= alu_res;
			ST_M_NL: begin
				if (flag_q)
					l_q <= alu_res;
			end
			ST_M_D2:   t0_q <= alu_res;
			ST_M_LR2:  t1_q <= alu_res;
			ST_M_3LR2: t3_q <= alu_res;
			ST_M_SM2:  t2_q <= alu_res;
			ST_M_T2:   flag_q <= tip;
			ST_M_NR: begin
				if (flag_q)
					r_q <= alu_res;
			end
			ST_M_CA: begin
				t0_q <= res_neg ? a_x : ap_x;
				t1_q <= res_neg ? ap_x : a_x;
			end
			ST_M_RLO: begin
				if (res_neg)
					r_q <= t0_q;
			end
			ST_M_RHI: begin
				if (res_pos)
					r_q <= t1_q;
			end
			ST_M_CB: begin
				t0_q <= res_neg ? am_x : a_x;
				t1_q <= res_neg ? a_x : am_x;
			end
			ST_M_LLO: begin
				if (res_neg)
					l_q <= t0_q;
			end
			ST_M_LHI: begin
				if (res_pos)
					l_q <= t1_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/ppmer_chk.sv =====
// Port-level checker for the parabolic edge reconstruction block, bound to the top level.
`timescale 1ns / 1ps

module ppmer_chk #(
	parameter int SAMPLE_BITS = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          column_start,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] left_edge,
	input logic signed [SAMPLE_BITS-1:0] right_edge
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_edge) && $stable(right_edge))
		else $error("result changed while stalled");

	// The first sample of a column needs no arithmetic and frees the input at once
	a_start_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && column_start |=> in_ready)
		else $error("column start request kept the block busy");

	// A result only appears at the end of a busy period
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	// Handing over a result returns the block to idle
	a_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("block still busy after producing a result");

endmodule

bind ppm_edge_reconstruction ppmer_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_ppmer_chk (.*);
